// File: sv/cdn_pkg.sv
// Shared types, constants and calendar tables for the calendar day number converter.
// Used by every module under sv/; no other dependencies.
package cdn_pkg;

    localparam logic [1:0] FUNC_TO_INDEX = 2'd0;
    localparam logic [1:0] FUNC_TO_DATE  = 2'd1;
    localparam logic [1:0] FUNC_ADD_DAYS = 2'd2;

    localparam logic [11:0] FIRST_YEAR     = 12'd2000;
    localparam logic [11:0] LAST_YEAR      = 12'd2099;
    localparam logic [15:0] LAST_INDEX     = 16'd36524;
    localparam logic [10:0] FOUR_YEAR_DAYS = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS      = 9'd365;
    localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
    localparam logic [2:0]  WEEK_DAYS      = 3'd7;
    localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd5;

    // Reciprocals that undershoot by at most one over the day number range.
    localparam logic [11:0] DIV1461_MUL = 12'd2870;   // floor(2^22 / 1461)
    localparam logic [13:0] DIV7_MUL    = 14'd9362;   // floor(2^16 / 7)

    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 40;

    typedef struct packed {
        logic        ok;
        logic [15:0] idx;
    } idx_beat_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] idx;
        logic [4:0]  group;
        logic [10:0] rem;
        logic [2:0]  weekday;
    } div_beat_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] idx;
        logic [2:0]  weekday;
    } res_beat_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the year before the first of the given month.
    function automatic logic [8:0] cum_days(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && month > 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: sv/cdn_date_stage.sv
// Two pipeline stages: date check and day number, then delta add and range check.
// Depends on cdn_pkg.
module cdn_date_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [11:0]        in_year,
    input  logic [3:0]         in_month,
    input  logic [4:0]         in_day,
    input  logic [15:0]        in_day_index,
    input  logic signed [16:0] day_delta,
    output logic               out_valid,
    input  logic               out_ready,
    output cdn_pkg::idx_beat_t out_beat
);

    logic [11:0] k_full;
    logic [6:0]  k;
    logic        leap;
    logic        date_ok;
    logic [16:0] date_idx;
    logic        base_ok_next;
    logic [15:0] base_next;
    logic signed [16:0] delta_next;

    logic               a_valid_reg;
    logic               base_ok_reg;
    logic [15:0]        base_reg;
    logic signed [16:0] delta_reg;
    logic               a_ready;

    logic signed [17:0] sum;
    cdn_pkg::idx_beat_t b_next;
    cdn_pkg::idx_beat_t b_reg;
    logic               b_valid_reg;
    logic               b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        k_full  = in_year - cdn_pkg::FIRST_YEAR;
        k       = k_full[6:0];
        leap    = (k[1:0] == 2'b00);
        date_ok = (in_year >= cdn_pkg::FIRST_YEAR) && (in_year <= cdn_pkg::LAST_YEAR)
                  && (in_day != 5'd0)
                  && (in_day <= cdn_pkg::month_days(in_month, leap));
        date_idx = 17'({10'b0, k} * 17'(cdn_pkg::YEAR_DAYS))
                 + 17'(({1'b0, k} + 8'd3) >> 2)
                 + 17'(cdn_pkg::cum_days(in_month, leap))
                 + 17'(in_day) - 17'd1;
        base_ok_next = 1'b0;
        base_next    = date_idx[15:0];
        delta_next   = '0;
        case (func)
            cdn_pkg::FUNC_TO_INDEX: begin
                base_ok_next = date_ok;
            end
            cdn_pkg::FUNC_TO_DATE: begin
                base_ok_next = (in_day_index <= cdn_pkg::LAST_INDEX);
                base_next    = in_day_index;
            end
            cdn_pkg::FUNC_ADD_DAYS: begin
                base_ok_next = date_ok;
                delta_next   = day_delta;
            end
            default: begin
                base_ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
        if (a_ready && in_valid) begin
            base_ok_reg <= base_ok_next;
            base_reg    <= base_next;
            delta_reg   <= delta_next;
        end
    end

    always_comb begin
        sum        = $signed({2'b00, base_reg}) + $signed({delta_reg[16], delta_reg});
        b_next.ok  = base_ok_reg && !sum[17] && (sum[16:0] <= {1'b0, cdn_pkg::LAST_INDEX});
        b_next.idx = sum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_beat  = b_reg;

endmodule

// File: sv/cdn_divide_stage.sv
// Two pipeline stages: reciprocal multiplies, then quotient fix-up for the
// four-year group and the weekday. Depends on cdn_pkg.
module cdn_divide_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cdn_pkg::idx_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output cdn_pkg::div_beat_t out_beat
);

    logic               c_valid_reg;
    logic               c_ok_reg;
    logic [15:0]        c_idx_reg;
    logic [15:0]        c_wv_reg;
    logic [26:0]        c_p_reg;
    logic [28:0]        c_pw_reg;
    logic [15:0]        wv_next;
    logic               c_ready;

    logic [4:0]         q;
    logic [15:0]        r0;
    logic [12:0]        q7;
    logic [15:0]        r7;
    cdn_pkg::div_beat_t d_next;
    cdn_pkg::div_beat_t d_reg;
    logic               d_valid_reg;
    logic               d_ready;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;
    assign wv_next  = in_beat.idx + 16'(cdn_pkg::EPOCH_WEEKDAY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= in_valid;
        end
        if (c_ready && in_valid) begin
            c_ok_reg  <= in_beat.ok;
            c_idx_reg <= in_beat.idx;
            c_wv_reg  <= wv_next;
            c_p_reg   <= 27'({11'b0, in_beat.idx} * 27'(cdn_pkg::DIV1461_MUL));
            c_pw_reg  <= 29'({13'b0, wv_next} * 29'(cdn_pkg::DIV7_MUL));
        end
    end

    // Quotients come out at most one low; one compare and subtract fixes them.
    always_comb begin
        q  = c_p_reg[26:22];
        r0 = c_idx_reg - 16'({11'b0, q} * 16'(cdn_pkg::FOUR_YEAR_DAYS));
        q7 = c_pw_reg[28:16];
        r7 = c_wv_reg - 16'({3'b0, q7} * 16'(cdn_pkg::WEEK_DAYS));
        d_next.ok  = c_ok_reg;
        d_next.idx = c_idx_reg;
        if (r0 >= 16'(cdn_pkg::FOUR_YEAR_DAYS)) begin
            d_next.group = q + 5'd1;
            d_next.rem   = 11'(r0 - 16'(cdn_pkg::FOUR_YEAR_DAYS));
        end else begin
            d_next.group = q;
            d_next.rem   = r0[10:0];
        end
        if (r7 >= 16'(cdn_pkg::WEEK_DAYS)) begin
            d_next.weekday = 3'(r7 - 16'(cdn_pkg::WEEK_DAYS));
        end else begin
            d_next.weekday = r7[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= c_valid_reg;
        end
        if (d_ready && c_valid_reg) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_beat  = d_reg;

endmodule

// File: sv/cdn_split_stage.sv
// Two pipeline stages: year and day of year from the group remainder, then
// month and day of month. Depends on cdn_pkg.
module cdn_split_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cdn_pkg::div_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output cdn_pkg::res_beat_t out_beat
);

    logic [1:0]  yo;
    logic [8:0]  doy_next;
    logic [11:0] year_next;
    logic        e_valid_reg;
    logic        e_ok_reg;
    logic [11:0] e_year_reg;
    logic [8:0]  e_doy_reg;
    logic        e_leap_reg;
    logic [15:0] e_idx_reg;
    logic [2:0]  e_wd_reg;
    logic        e_ready;

    logic [3:0]         month;
    logic [8:0]         dom;
    cdn_pkg::res_beat_t f_next;
    cdn_pkg::res_beat_t f_reg;
    logic               f_valid_reg;
    logic               f_ready;

    localparam logic [10:0] YEAR2_START = 11'(cdn_pkg::LEAP_YEAR_DAYS);
    localparam logic [10:0] YEAR3_START = 11'(cdn_pkg::LEAP_YEAR_DAYS)
                                        + 11'(cdn_pkg::YEAR_DAYS);
    localparam logic [10:0] YEAR4_START = 11'(cdn_pkg::LEAP_YEAR_DAYS + 2 * cdn_pkg::YEAR_DAYS);

    assign f_ready  = !f_valid_reg || out_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    always_comb begin
        if (in_beat.rem < YEAR2_START) begin
            yo       = 2'd0;
            doy_next = in_beat.rem[8:0];
        end else if (in_beat.rem < YEAR3_START) begin
            yo       = 2'd1;
            doy_next = 9'(in_beat.rem - YEAR2_START);
        end else if (in_beat.rem < YEAR4_START) begin
            yo       = 2'd2;
            doy_next = 9'(in_beat.rem - YEAR3_START);
        end else begin
            yo       = 2'd3;
            doy_next = 9'(in_beat.rem - YEAR4_START);
        end
        year_next = cdn_pkg::FIRST_YEAR + {5'b0, in_beat.group, 2'b00} + {10'b0, yo};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= in_valid;
        end
        if (e_ready && in_valid) begin
            e_ok_reg   <= in_beat.ok;
            e_year_reg <= year_next;
            e_doy_reg  <= doy_next;
            e_leap_reg <= (yo == 2'd0);
            e_idx_reg  <= in_beat.idx;
            e_wd_reg   <= in_beat.weekday;
        end
    end

    // Count month starts at or before the day of year; all compares run in parallel.
    always_comb begin
        month = 4'd1;
        for (int i = 2; i <= 12; i++) begin
            if (e_doy_reg >= cdn_pkg::cum_days(4'(i), e_leap_reg)) begin
                month = month + 4'd1;
            end
        end
        dom = e_doy_reg - cdn_pkg::cum_days(month, e_leap_reg) + 9'd1;
        if (e_ok_reg) begin
            f_next.ok      = 1'b1;
            f_next.year    = e_year_reg;
            f_next.month   = month;
            f_next.day     = dom[4:0];
            f_next.idx     = e_idx_reg;
            f_next.weekday = e_wd_reg;
        end else begin
            f_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_ready) begin
            f_valid_reg <= e_valid_reg;
        end
        if (f_ready && e_valid_reg) begin
            f_reg <= f_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_beat  = f_reg;

endmodule

// File: sv/calendar_day_number_converter.sv
// Calendar day number converter: Gregorian dates 2000..2099 to day numbers and back.
// Each accepted input beat passes the date, divide and split stages and then the output register to the m_ side.
// Throughput: one beat per cycle while m_tready is high; each of the six stages plus the
// output register advances whenever its successor has room, so bubbles fill during a stall.
// Reset: aresetn low, synchronous, clears all valid bits; no results are pending.
// Depends on cdn_pkg, cdn_date_stage, cdn_divide_stage, cdn_split_stage.
module calendar_day_number_converter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: in_year[11:0], in_month[3:0], in_day[4:0],
    // in_day_index[15:0], day_delta[16:0], two zero pad bits
    input  logic [cdn_pkg::TDATA_IN_W-1:0]  s_tdata,
    // s_tuser: func[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: out_year[11:0], out_month[3:0], out_day[4:0],
    // out_day_index[15:0], weekday[2:0]
    output logic [cdn_pkg::TDATA_OUT_W-1:0] m_tdata,
    // m_tuser: ok
    output logic                            m_tuser
);

    logic               date_valid;
    logic               date_ready;
    cdn_pkg::idx_beat_t date_beat;
    logic               div_valid;
    logic               div_ready;
    cdn_pkg::div_beat_t div_beat;
    logic               split_valid;
    logic               split_ready;
    cdn_pkg::res_beat_t split_beat;

    logic               out_valid_reg;
    cdn_pkg::res_beat_t out_reg;

    cdn_date_stage u_date (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .func         (s_tuser),
        .in_year      (s_tdata[11:0]),
        .in_month     (s_tdata[15:12]),
        .in_day       (s_tdata[20:16]),
        .in_day_index (s_tdata[36:21]),
        .day_delta    ($signed(s_tdata[53:37])),
        .out_valid    (date_valid),
        .out_ready    (date_ready),
        .out_beat     (date_beat)
    );

    cdn_divide_stage u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (date_valid),
        .in_ready  (date_ready),
        .in_beat   (date_beat),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_beat  (div_beat)
    );

    cdn_split_stage u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_beat   (div_beat),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_beat  (split_beat)
    );

    assign split_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (split_ready) begin
            out_valid_reg <= split_valid;
        end
        if (split_ready && split_valid) begin
            out_reg <= split_beat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.ok;
    assign m_tdata  = {out_reg.weekday, out_reg.idx, out_reg.day, out_reg.month, out_reg.year};

`ifndef SYNTHESIS
    a_ok_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[11:0] >= cdn_pkg::FIRST_YEAR
                                   && m_tdata[11:0] <= cdn_pkg::LAST_YEAR))
        else $error("ok result with year outside 2000..2099");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed result carries nonzero fields");

    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[39:37] < cdn_pkg::WEEK_DAYS
                                   && m_tdata[20:16] != 5'd0
                                   && m_tdata[15:12] != 4'd0
                                   && m_tdata[15:12] <= 4'd12
                                   && m_tdata[36:21] <= cdn_pkg::LAST_INDEX))
        else $error("ok result with weekday, month, day or day number out of range");
`endif

endmodule

// File: test/tb_calendar_day_number_converter.sv
`timescale 1ns / 100ps
// Self-checking testbench for calendar_day_number_converter: a calendar scoreboard class
// predicts each result from the request beat; plain tasks drive the stream ports.
// Depends on cdn_pkg and the converter RTL under sv/.
module tb_calendar_day_number_converter;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         LIMIT_CYCLES = 200000;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         DRAIN_CYCLES = 24;
    localparam int         RANDOM_ITEMS = 2000;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [15:0]        day_index;
        logic signed [16:0] delta;
    } cal_request_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] day_index;
        logic [2:0]  weekday;
    } cal_result_t;

    class calendar_scoreboard;
        cal_result_t expected_q[$];
        int          errors = 0;

        static function int month_length(int yr, int mo);
            case (mo)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return (yr % 4 == 0) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function int year_length(int yr);
            return (yr % 4 == 0) ? 366 : 365;
        endfunction

        static function bit date_valid(int yr, int mo, int dy);
            if (yr < int'(cdn_pkg::FIRST_YEAR) || yr > int'(cdn_pkg::LAST_YEAR)) return 0;
            return dy >= 1 && dy <= month_length(yr, mo);
        endfunction

        static function int date_to_day_number(int yr, int mo, int dy);
            int n;
            n = 0;
            for (int yy = int'(cdn_pkg::FIRST_YEAR); yy < yr; yy++) n += year_length(yy);
            for (int mm = 1; mm < mo; mm++) n += month_length(yr, mm);
            return n + dy - 1;
        endfunction

        static function cal_result_t day_number_to_date(int n);
            cal_result_t res;
            int          yr;
            int          mo;
            int          rest;
            yr   = int'(cdn_pkg::FIRST_YEAR);
            mo   = 1;
            rest = n;
            while (rest >= year_length(yr)) begin
                rest -= year_length(yr);
                yr++;
            end
            while (rest >= month_length(yr, mo)) begin
                rest -= month_length(yr, mo);
                mo++;
            end
            res.ok        = 1'b1;
            res.year      = yr[11:0];
            res.month     = mo[3:0];
            res.day       = 5'(rest + 1);
            res.day_index = n[15:0];
            res.weekday   = 3'((n + 5) % 7);
            return res;
        endfunction

        static function cal_result_t convert_request(cal_request_t rq);
            cal_result_t res;
            int          base;
            int          sum;
            res = '0;
            case (rq.func)
                cdn_pkg::FUNC_TO_INDEX: begin
                    if (date_valid(rq.year, rq.month, rq.day))
                        res = day_number_to_date(date_to_day_number(rq.year, rq.month, rq.day));
                end
                cdn_pkg::FUNC_TO_DATE: begin
                    if (rq.day_index <= cdn_pkg::LAST_INDEX)
                        res = day_number_to_date(int'(rq.day_index));
                end
                cdn_pkg::FUNC_ADD_DAYS: begin
                    if (date_valid(rq.year, rq.month, rq.day)) begin
                        base = date_to_day_number(rq.year, rq.month, rq.day);
                        sum  = base + int'(rq.delta);
                        if (sum >= 0 && sum <= int'(cdn_pkg::LAST_INDEX))
                            res = day_number_to_date(sum);
                    end
                end
                default: res = '0;
            endcase
            return res;
        endfunction

        function void note_request(cal_request_t rq);
            expected_q.push_back(convert_request(rq));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(cal_result_t got);
            cal_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("out_year", want.year, got.year);
            compare_field("out_month", want.month, got.month);
            compare_field("out_day", want.day, got.day);
            compare_field("out_day_index", want.day_index, got.day_index);
            compare_field("weekday", want.weekday, got.weekday);
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [cdn_pkg::TDATA_IN_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [cdn_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                            m_tuser;

    calendar_scoreboard sb = new();
    bit                 stall_request = 0;
    int                 cycle_count = 0;

    calendar_day_number_converter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every result beat accepted at a rising edge.
    always @(posedge aclk) begin
        cal_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok        = m_tuser;
            got.year      = m_tdata[11:0];
            got.month     = m_tdata[15:12];
            got.day       = m_tdata[20:16];
            got.day_index = m_tdata[36:21];
            got.weekday   = m_tdata[39:37];
            sb.check_result(got);
        end
    end

    // Receiver: segments of differing stall patterns, plus one long hold-off on request.
    initial begin
        int          mode;
        int          seg;
        int          hold_count;
        logic [15:0] pattern;
        bit          stall_taken;
        stall_taken = 0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            mode    = $urandom_range(0, 3);
            seg     = $urandom_range(16, 160);
            pattern = 16'($urandom);
            repeat (seg) begin
                @(negedge aclk);
                if (stall_request && !stall_taken) begin
                    m_tready <= 1'b0;
                    for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++)
                        @(negedge aclk);
                    stall_taken = 1;
                end else begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 7) != 0);
                        default: begin
                            m_tready <= pattern[0];
                            pattern  = {pattern[0], pattern[15:1]};
                        end
                    endcase
                end
            end
        end
    end

    function automatic cal_request_t make_request(logic [1:0] func, int yr, int mo, int dy,
                                                  int idx, int delta);
        cal_request_t rq;
        rq.func      = func;
        rq.year      = yr[11:0];
        rq.month     = mo[3:0];
        rq.day       = dy[4:0];
        rq.day_index = idx[15:0];
        rq.delta     = delta[16:0];
        return rq;
    endfunction

    function automatic cal_request_t random_request();
        cal_request_t rq;
        int           pick;
        int           base;
        int           target;
        rq.func      = 2'($urandom);
        rq.year      = 12'($urandom);
        rq.month     = 4'($urandom);
        rq.day       = 5'($urandom);
        rq.day_index = 16'($urandom);
        rq.delta     = 17'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 75 && !(pick >= 30 && pick < 45)) begin
            // Well-formed date for the date-reading operations.
            rq.func  = (pick < 30) ? cdn_pkg::FUNC_TO_INDEX : cdn_pkg::FUNC_ADD_DAYS;
            rq.year  = 12'($urandom_range(cdn_pkg::FIRST_YEAR, cdn_pkg::LAST_YEAR));
            rq.month = 4'($urandom_range(1, 12));
            rq.day   = 5'($urandom_range(1,
                           calendar_scoreboard::month_length(rq.year, rq.month)));
        end
        if (pick < 30) begin
            rq.func = cdn_pkg::FUNC_TO_INDEX;
        end else if (pick < 45) begin
            rq.func = cdn_pkg::FUNC_TO_DATE;
            if ($urandom_range(0, 9) != 0)
                rq.day_index = 16'($urandom_range(0, cdn_pkg::LAST_INDEX));
        end else if (pick < 75) begin
            base = calendar_scoreboard::date_to_day_number(rq.year, rq.month, rq.day);
            case ($urandom_range(0, 3))
                0: rq.delta = 17'(int'($urandom_range(0, 800)) - 400);
                1: rq.delta = 17'($urandom);
                2: begin
                    // Aim at either end of the day number range.
                    target = $urandom_range(0, 1)
                           ? int'($urandom_range(0, 6)) - 3
                           : int'(cdn_pkg::LAST_INDEX) + int'($urandom_range(0, 6)) - 3;
                    rq.delta = 17'(target - base);
                end
                default: rq.delta = 17'(int'($urandom_range(0, 80000)) - 40000);
            endcase
        end else if (pick >= 90) begin
            rq.func = FUNC_UNUSED;
        end
        return rq;
    endfunction

    task automatic send_request(cal_request_t rq);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rq.delta, rq.day_index, rq.day, rq.month, rq.year};
        s_tuser  <= rq.func;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(rq);
    endtask

    task automatic sender_gap(int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic send_directed();
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2000, 1, 1, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2099, 12, 31, 65535, 65535));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2000, 2, 29, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2001, 2, 29, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2100, 1, 1, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 1999, 12, 31, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2050, 0, 10, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2050, 13, 10, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 4095, 15, 31, 65535, -1));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2020, 4, 31, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_INDEX, 2021, 6, 0, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_DATE, 0, 0, 0, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_DATE, 4095, 15, 31, 36524, -1));
        send_request(make_request(cdn_pkg::FUNC_TO_DATE, 2000, 1, 1, 36525, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_DATE, 2000, 1, 1, 65535, 0));
        send_request(make_request(cdn_pkg::FUNC_TO_DATE, 2000, 1, 1, 1460, 0));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2000, 1, 1, 0, -1));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2099, 12, 31, 0, 1));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2024, 7, 15, 0, 0));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2000, 1, 1, 0, 36524));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2099, 12, 31, 0, -36524));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2099, 12, 31, 0, -65536));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2000, 1, 1, 0, 65535));
        send_request(make_request(cdn_pkg::FUNC_ADD_DAYS, 2023, 2, 29, 0, 0));
        send_request(make_request(FUNC_UNUSED, 2000, 1, 1, 0, 0));
    endtask

    initial begin
        int sent;
        int burst;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_directed();
        pause_until_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 600 && sent < 640) begin
                // Hold the receiver off while offering back-to-back beats.
                stall_request = 1;
                repeat (40) send_request(random_request());
                sent += 40;
            end else if (sent >= 1200 && sent < 1210) begin
                pause_until_drained();
                sent += 10;
                repeat (10) send_request(random_request());
            end else begin
                burst = $urandom_range(1, 40);
                repeat (burst) send_request(random_request());
                sent += burst;
                if ($urandom_range(0, 2) != 0)
                    sender_gap($urandom_range(1, 6));
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
